// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while in reset.
`define SLQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SLQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/slq_pkg.sv -----
// Types and codes for the sortable linear queue.
`default_nettype none
package slq_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;
    localparam logic [1:0] OP_POP   = 2'd2;
    localparam logic [1:0] OP_SORT  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic [7:0]         count;
        logic               empty_res;
    } out_t;

endpackage
`default_nettype wire

// ----- hdl/slq_mem.sv -----
// Entry storage: one write port, one registered read port.
`default_nettype none
module slq_mem #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [ADDR_W-1:0]        waddr,
    input  wire logic signed [31:0]       wdata,
    input  wire logic                     re,
    input  wire logic [ADDR_W-1:0]        raddr,
    output      logic signed [31:0]       rdata
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- hdl/sortable_linear_queue_unit.sv -----
// Clear and push go from idle straight to the done state; pop first passes through a read state.
// A new request is taken only after the last one's result has been loaded into the output reg.
// Sort: ascending signed insertion sort over the live entries, through the key, compare
// and insert states, with input held off meanwhile.
// Input is taken only when the sequencer is idle; a result may wait in the output reg.
// Reset (async, active low) empties the queue; stored entries are left as they are.
`default_nettype none
module sortable_linear_queue_unit
    import slq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output      logic in_ready,
    input  wire in_t  in_req,
    output      logic out_valid,
    input  wire logic out_ready,
    output      out_t out_req
);

    `include "assert_macros.svh"

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int CNT_W  = (PTR_W > 8) ? PTR_W : 8;
    localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_KEY  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_INS  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [PTR_W-1:0]   i_reg, i_next;
    logic [PTR_W-1:0]   j_reg, j_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] res_data_reg, res_data_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               out_valid_reg;
    out_t               out_reg;

    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata, mem_rdata;

    logic               accept, load_out, key_less;
    logic [PTR_W-1:0]   i_inc, i_dec, j_dec, head_inc;
    logic [CNT_W-1:0]   cnt_wide;

    slq_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign key_less = key_reg < mem_rdata;
    assign i_inc    = i_reg + PTR_W'(1);
    assign i_dec    = i_reg - PTR_W'(1);
    assign j_dec    = j_reg - PTR_W'(1);
    assign head_inc = head_reg + PTR_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        key_next        = key_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = tail_reg[ADDR_W-1:0];
        mem_wdata       = in_req.value;
        mem_re          = 1'b0;
        mem_raddr       = head_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_data_next   = '0;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    unique case (in_req.op)
                        OP_CLEAR:
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        OP_PUSH:
                        begin
                            if (tail_reg == DEPTH_P)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                tail_next = tail_reg + PTR_W'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (head_reg == tail_reg)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        OP_SORT:
                        begin
                            i_next = head_inc;
                            if (head_reg != tail_reg && head_inc < tail_reg)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_inc[ADDR_W-1:0];
                                state_next = S_KEY;
                            end
                        end
                    endcase
                end
            end
            S_POP:
            begin
                res_data_next = mem_rdata;
                head_next     = head_inc;
                state_next    = S_DONE;
            end
            S_KEY:
            begin
                key_next   = mem_rdata;
                j_next     = i_reg;
                mem_re     = 1'b1;
                mem_raddr  = i_dec[ADDR_W-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[ADDR_W-1:0];
                if (key_less)
                begin
                    mem_wdata = mem_rdata;
                    j_next    = j_dec;
                    if (j_dec > head_reg)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = j_dec[ADDR_W-1:0] - ADDR_W'(1);
                    end
                    else
                    begin
                        state_next = S_INS;
                    end
                end
                else
                begin
                    mem_wdata = key_reg;
                    i_next    = i_inc;
                    if (i_inc < tail_reg)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = i_inc[ADDR_W-1:0];
                        state_next = S_KEY;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_INS:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[ADDR_W-1:0];
                mem_wdata = key_reg;
                i_next    = i_inc;
                if (i_inc < tail_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = i_inc[ADDR_W-1:0];
                    state_next = S_KEY;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cnt_wide = CNT_W'(tail_reg) - CNT_W'(head_reg);

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        key_reg        <= key_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        if (load_out)
        begin
            out_reg.data      <= res_data_reg;
            out_reg.status    <= res_status_reg;
            out_reg.count     <= cnt_wide[7:0];
            out_reg.empty_res <= (head_reg == tail_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_req   = out_reg;

    `SLQ_ASSERT(a_head_le_tail, head_reg <= tail_reg, "head passed tail")
    `SLQ_ASSERT(a_tail_le_depth, tail_reg <= DEPTH_P, "tail beyond depth")
    `SLQ_ASSERT(a_cmp_window, (state_reg == S_CMP) |-> (j_reg > head_reg && j_reg < tail_reg),
        "sort index outside live window")
    `SLQ_ASSERT(a_sort_keeps_bounds, (state_reg == S_CMP || state_reg == S_KEY) |=>
        ($stable(head_reg) && $stable(tail_reg)), "bounds changed during sort")

endmodule
`default_nettype wire

// ----- dv/slq_checker.sv -----
// Queue shadow model and result scoreboard for the sortable linear queue.
module slq_checker
    import slq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_ready,
    input  wire in_t  in_req,
    input  wire logic out_valid,
    input  wire logic out_ready,
    input  wire out_t out_req,
    output int        fail_count,
    output int        pending
);

    logic signed [31:0] q_mem [DEPTH];
    int                 q_head;
    int                 q_tail;
    out_t               want_q [$];
    out_t               want;
    int                 errs;

    // Apply one request to the shadow queue and return the result it should produce.
    function automatic out_t apply_request(in_t r);
        out_t               res;
        logic signed [31:0] key;
        int                 j;
        res = '0;
        res.status = ST_OK;
        case (r.op)
            OP_CLEAR:
            begin
                q_head = 0;
                q_tail = 0;
            end
            OP_PUSH:
            begin
                if (q_tail >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    q_mem[q_tail] = r.value;
                    q_tail++;
                end
            end
            OP_POP:
            begin
                if (q_head >= q_tail)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.data = q_mem[q_head];
                    q_head++;
                end
            end
            OP_SORT:
            begin
                // ascending signed insertion sort over the live window only
                for (int i = q_head + 1; i < q_tail; i++)
                begin
                    key = q_mem[i];
                    j = i;
                    while (j > q_head && key < q_mem[j - 1])
                    begin
                        q_mem[j] = q_mem[j - 1];
                        j--;
                    end
                    q_mem[j] = key;
                end
            end
        endcase
        res.count = 8'(q_tail - q_head);
        res.empty_res = (q_head == q_tail);
        return res;
    endfunction

    task automatic flag(input string field, input longint exp_v, input longint act_v);
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_v, act_v);
        errs++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_head = 0;
            q_tail = 0;
            want_q.delete();
            errs = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                want_q.push_back(apply_request(in_req));
            end
            if (out_valid && out_ready)
            begin
                if (want_q.size() == 0)
                begin
                    $display("%0t: unexpected result: data=%0d status=%0d count=%0d empty=%0b",
                             $time, out_req.data, out_req.status, out_req.count,
                             out_req.empty_res);
                    errs++;
                end
                else
                begin
                    want = want_q.pop_front();
                    if (out_req.data !== want.data)
                        flag("data", want.data, out_req.data);
                    if (out_req.status !== want.status)
                        flag("status", want.status, out_req.status);
                    if (out_req.count !== want.count)
                        flag("count", want.count, out_req.count);
                    if (out_req.empty_res !== want.empty_res)
                        flag("empty_res", want.empty_res, out_req.empty_res);
                end
            end
            pending <= want_q.size();
            fail_count <= errs;
        end
    end

endmodule

// ----- dv/testbench.sv -----
// Stimulus, flow control and verdict for the sortable linear queue.
module testbench;
    import slq_pkg::*;

    localparam int DEPTH      = 128;
    localparam int LIMIT      = 1_000_000;
    localparam int N_ITEMS    = 900;
    localparam int FILL_ITEMS = 2 * DEPTH + 10;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    in_t  in_req    = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    out_t out_req;

    int fail_count;
    int pending;
    int sent        = 0;
    int burst_left  = 0;
    int shadow_head = 0;
    int shadow_tail = 0;
    int cycles      = 0;
    int stall_left  = 0;
    int ready_mode  = 0;
    int mode_age    = 0;

    always #4 clk = ~clk;

    sortable_linear_queue_unit #(.DEPTH(DEPTH)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_req   (in_req),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_req  (out_req)
    );

    slq_checker #(.DEPTH(DEPTH)) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_req   (out_req),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("** sortable_linear_queue_unit: FAILED **");
            $finish;
        end
    end

    // receiver: stalls out_ready at random, under a ready mode that is itself redrawn at random
    always @(posedge clk)
    begin
        mode_age++;
        if (mode_age >= 200)
        begin
            mode_age = 0;
            ready_mode = $urandom_range(0, 2);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (ready_mode != 0 && $urandom_range(0, 3) < ready_mode)
        begin
            stall_left = $urandom_range(0, 11);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    function automatic logic signed [31:0] rand_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7FFF_FFFF;
                    2:       v = 32'sh0000_0000;
                    default: v = -32'sd1;
                endcase
            end
            1, 2:    v = $signed(32'($urandom_range(0, 31))) - 32'sd16;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic issue(input logic [1:0] op, input logic signed [31:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_req   <= '{op: op, value: v};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        sent++;
        case (op)
            OP_CLEAR:
            begin
                shadow_head = 0;
                shadow_tail = 0;
            end
            OP_PUSH: if (shadow_tail < DEPTH) shadow_tail++;
            OP_POP:  if (shadow_head < shadow_tail) shadow_head++;
            default: ;
        endcase
    endtask

    // fill to the top, refuse pushes, sort full and partial windows, drain past empty
    task automatic fill_episode();
        issue(OP_CLEAR, rand_value());
        repeat (DEPTH) issue(OP_PUSH, rand_value());
        repeat ($urandom_range(1, 3)) issue(OP_PUSH, rand_value());
        issue(OP_SORT, rand_value());
        repeat ($urandom_range(1, DEPTH - 1)) issue(OP_POP, rand_value());
        issue(OP_PUSH, rand_value());
        issue(OP_SORT, rand_value());
        while (shadow_head < shadow_tail) issue(OP_POP, rand_value());
        issue(OP_POP, rand_value());
        issue(OP_PUSH, rand_value());
        issue(OP_CLEAR, rand_value());
    endtask

    task automatic mixed_run(input int n);
        int r;
        if ($urandom_range(0, 1) == 0)
            issue(OP_CLEAR, rand_value());
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                issue(OP_PUSH, rand_value());
            else if (r < 78 || (r < 93 && shadow_tail - shadow_head > 24))
                issue(OP_POP, rand_value());
            else if (r < 93)
                issue(OP_SORT, rand_value());
            else
                issue(OP_CLEAR, rand_value());
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(OP_POP,  32'sd0);
        issue(OP_SORT, 32'sd0);
        issue(OP_PUSH, 32'sd5);
        issue(OP_SORT, 32'sd0);
        issue(OP_POP,  32'sd0);
        issue(OP_PUSH, 32'sh7FFF_FFFF);
        issue(OP_PUSH, 32'sh8000_0000);
        issue(OP_PUSH, 32'sd0);
        issue(OP_PUSH, -32'sd1);
        issue(OP_PUSH, 32'sd1);
        issue(OP_PUSH, 32'sh8000_0000);
        issue(OP_SORT, -32'sd1);
        repeat (6) issue(OP_POP, 32'sd0);
        issue(OP_POP,   32'sd0);
        issue(OP_PUSH,  32'sd3);
        issue(OP_CLEAR, 32'sd0);
        issue(OP_POP,   32'sd0);
        issue(OP_SORT,  32'sd0);

        fill_episode();
        while (sent < N_ITEMS - FILL_ITEMS)
        begin
            if ($urandom_range(0, 39) == 0)
                fill_episode();
            else
                mixed_run($urandom_range(4, 40));
        end
        fill_episode();
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("** sortable_linear_queue_unit: PASSED **");
        end
        else
        begin
            $display("** sortable_linear_queue_unit: FAILED **");
        end
        $finish;
    end

endmodule
